// ----- sv/qrms_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrms_pkg: QR mode segmenter types and constants
// Mode codes, register indexes, result record and the per-segment cost helpers.
// ----------------------------------------------------------------------------
package qrms_pkg;

  localparam int CHAR_W  = 8;
  localparam int LEN_W   = 13;
  localparam int TOT_W   = 16;
  localparam int CFG_W   = 12;
  localparam int CFG_IDX_W = 3;

  // Streak counters saturate here.
  localparam int MAX_CHARS = 4096;
  localparam logic [LEN_W-1:0] RUN_CAP = LEN_W'(MAX_CHARS < 8191 ? MAX_CHARS : 8191);

  typedef enum logic [1:0] {
    MODE_NUM   = 2'd0,
    MODE_ALNUM = 2'd1,
    MODE_BYTE  = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_BEFORE_BYTE   = 3'd0,
    CFG_NUM_BEFORE_ALNUM  = 3'd1,
    CFG_ALNUM_BEFORE_BYTE = 3'd2,
    CFG_BYTE_TO_ALNUM     = 3'd3,
    CFG_BYTE_TO_NUM       = 3'd4,
    CFG_ALNUM_TO_NUM      = 3'd5
  } cfg_idx_t;

  // Version size classes for the character count field.
  typedef enum logic [1:0] {
    SIZE_SMALL  = 2'd0,
    SIZE_MEDIUM = 2'd1,
    SIZE_LARGE  = 2'd2
  } size_cls_t;

  typedef struct packed {
    mode_t            mode;
    logic [LEN_W-1:0] len;
  } seg_t;

  typedef struct packed {
    mode_t            mode;
    logic [LEN_W-1:0] len;
    logic [TOT_W-1:0] bits_small;
    logic [TOT_W-1:0] bits_medium;
    logic [TOT_W-1:0] bits_large;
    logic             final_flag;
  } res_t;

  function automatic mode_t classify(input logic [CHAR_W-1:0] c);
    mode_t m;
    if (c >= 8'h30 && c <= 8'h39) begin
      m = MODE_NUM;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      m = MODE_ALNUM;
    end else if (c == 8'h20 || c == 8'h24 || c == 8'h25 || c == 8'h2A || c == 8'h2B ||
                 c == 8'h2D || c == 8'h2E || c == 8'h2F || c == 8'h3A) begin
      m = MODE_ALNUM;
    end else begin
      m = MODE_BYTE;
    end
    return m;
  endfunction

  function automatic logic [LEN_W-1:0] sat_run(input logic [LEN_W:0] v);
    logic [LEN_W-1:0] r;
    if (v > {1'b0, RUN_CAP}) begin
      r = RUN_CAP;
    end else begin
      r = v[LEN_W-1:0];
    end
    return r;
  endfunction

  // Mode indicator plus data bits; len / 3 via reciprocal 10923 / 2^15.
  function automatic logic [TOT_W-1:0] seg_data_bits(input mode_t m,
                                                     input logic [LEN_W-1:0] len);
    logic [26:0]      prod;
    logic [11:0]      q;
    logic [LEN_W:0]   rem;
    logic [1:0]       r;
    logic [TOT_W-1:0] tail;
    logic [TOT_W-1:0] b;
    prod = 27'(len) * 27'(14'd10923);
    q    = prod[26:15];
    rem  = {1'b0, len} - ((LEN_W+1)'(q) * (LEN_W+1)'(3));
    r    = rem[1:0];
    tail = (r == 2'd1) ? 16'd4 : ((r == 2'd2) ? 16'd7 : 16'd0);
    case (m)
      MODE_NUM:   b = 16'd4 + (16'(q) * 16'd10) + tail;
      MODE_ALNUM: b = 16'd4 + (16'(len[LEN_W-1:1]) * 16'd11) + (len[0] ? 16'd6 : 16'd0);
      default:    b = 16'd4 + {len, 3'b000};
    endcase
    return b;
  endfunction

  function automatic logic [TOT_W-1:0] cc_bits(input mode_t m, input size_cls_t s);
    logic [4:0] v;
    case (m)
      MODE_NUM: begin
        case (s)
          SIZE_SMALL:  v = 5'd10;
          SIZE_MEDIUM: v = 5'd12;
          default:     v = 5'd14;
        endcase
      end
      MODE_ALNUM: begin
        case (s)
          SIZE_SMALL:  v = 5'd9;
          SIZE_MEDIUM: v = 5'd11;
          default:     v = 5'd13;
        endcase
      end
      default: begin
        case (s)
          SIZE_SMALL:  v = 5'd8;
          default:     v = 5'd16;
        endcase
      end
    endcase
    return TOT_W'(v);
  endfunction

endpackage
`default_nettype wire

// ----- sv/qr_mode_segmenter_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qr_mode_segmenter_unit: QR mode segmentation of a byte stream
// Classes each byte, tracks the running mode and emits closed segments with
// running bit totals for the three version size classes.
// ----------------------------------------------------------------------------
// Feed one message byte per beat; the block accepts one byte every cycle while
// its four-entry result queue holds two results or fewer. Results pass the
// input, segment-list and segment-cost registers into the queue. A byte that
// both closes a segment by demotion and carries last_char yields two result
// beats, closed segment first, and the output port then sets the sustained
// rate. Mark the first byte of each message with first_char to clear the totals
// and start a fresh run; last_char flushes the open segment with final_flag
// set. Write configuration only while no bytes or results are in flight.
module qr_mode_segmenter_unit (
  input  wire                              clk,
  input  wire                              rst_n,
  // input byte channel
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [qrms_pkg::CHAR_W-1:0]      in_char_in,
  input  wire                              in_first_char,
  input  wire                              in_last_char,
  // result channel
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [1:0]                       out_seg_mode,
  output logic [qrms_pkg::LEN_W-1:0]       out_seg_len,
  output logic [qrms_pkg::TOT_W-1:0]       out_bits_small,
  output logic [qrms_pkg::TOT_W-1:0]       out_bits_medium,
  output logic [qrms_pkg::TOT_W-1:0]       out_bits_large,
  output logic                             out_final_flag,
  // configuration write channel
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [qrms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [qrms_pkg::CFG_W-1:0]       cfg_data
);
  import qrms_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // ---------------------------------------------------------------- config
  logic [CFG_W-1:0] cfg_nbb_r, cfg_nba_r, cfg_abb_r, cfg_b2a_r, cfg_b2n_r, cfg_a2n_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_nbb_r <= 12'd4;
      cfg_nba_r <= 12'd7;
      cfg_abb_r <= 12'd11;
      cfg_b2a_r <= 12'd11;
      cfg_b2n_r <= 12'd6;
      cfg_a2n_r <= 12'd13;
    end else if (cfg_valid && cfg_ready) begin
      // indexes past the list are dropped
      case (cfg_idx_t'(cfg_index))
        CFG_NUM_BEFORE_BYTE:   cfg_nbb_r <= cfg_data;
        CFG_NUM_BEFORE_ALNUM:  cfg_nba_r <= cfg_data;
        CFG_ALNUM_BEFORE_BYTE: cfg_abb_r <= cfg_data;
        CFG_BYTE_TO_ALNUM:     cfg_b2a_r <= cfg_data;
        CFG_BYTE_TO_NUM:       cfg_b2n_r <= cfg_data;
        CFG_ALNUM_TO_NUM:      cfg_a2n_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------- pipeline flow
  // The whole pipe moves together; it holds when the result queue could not
  // absorb two more beats.
  logic [QCNT_W-1:0] q_cnt_r, q_cnt_nxt;
  logic              advance;

  assign advance  = (q_cnt_r <= QCNT_W'(QDEPTH - 2));
  assign in_ready = advance;

  // ------------------------------------------------- stage 1: input register
  logic              s1_vld_r;
  logic [CHAR_W-1:0] s1_char_r;
  logic              s1_first_r, s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (advance) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_char_r  <= in_char_in;
      s1_first_r <= in_first_char;
      s1_last_r  <= in_last_char;
    end
  end

  // ------------------------------------------------ stage 1: mode tracking
  mode_t            mode_r, mode_nxt;
  logic [LEN_W-1:0] hit_r, hit_nxt;
  logic [LEN_W-1:0] miss_r, miss_nxt;

  mode_t            cls;
  logic [LEN_W-1:0] miss_inc;
  logic             promote, demote;
  logic             d_vld, l_vld;
  seg_t             d_seg, l_seg;

  always_comb begin
    cls      = classify(s1_char_r);
    miss_inc = sat_run({1'b0, miss_r} + 14'd1);
    promote  = 1'b0;
    demote   = 1'b0;
    mode_nxt = mode_r;
    hit_nxt  = hit_r;
    miss_nxt = miss_r;
    d_vld    = 1'b0;
    d_seg    = '{mode: mode_r, len: hit_r};

    if (s1_first_r) begin
      // start a fresh run; no switching judged
      mode_nxt = cls;
      hit_nxt  = 13'd1;
      miss_nxt = '0;
    end else if (cls == mode_r) begin
      // a match also absorbs the pending misses
      hit_nxt  = sat_run({1'b0, hit_r} + {1'b0, miss_r} + 14'd1);
      miss_nxt = '0;
    end else if (cls > mode_r) begin
      if (mode_r == MODE_NUM && cls == MODE_BYTE) begin
        promote = hit_r < {1'b0, cfg_nbb_r};
      end else if (mode_r == MODE_NUM && cls == MODE_ALNUM) begin
        promote = hit_r < {1'b0, cfg_nba_r};
      end else if (mode_r == MODE_ALNUM && cls == MODE_BYTE) begin
        promote = hit_r < {1'b0, cfg_abb_r};
      end
      if (promote) begin
        mode_nxt = cls;
        hit_nxt  = sat_run({1'b0, hit_r} + {1'b0, miss_inc});
        miss_nxt = '0;
      end else begin
        miss_nxt = miss_inc;
      end
    end else begin
      if (mode_r == MODE_BYTE && cls == MODE_ALNUM) begin
        demote = miss_inc >= {1'b0, cfg_b2a_r};
      end else if (mode_r == MODE_BYTE && cls == MODE_NUM) begin
        demote = miss_inc >= {1'b0, cfg_b2n_r};
      end else if (mode_r == MODE_ALNUM && cls == MODE_NUM) begin
        demote = miss_inc >= {1'b0, cfg_a2n_r};
      end
      if (demote) begin
        // close the running segment; the misses seed the new run
        d_vld    = 1'b1;
        mode_nxt = cls;
        hit_nxt  = miss_inc;
        miss_nxt = '0;
      end else begin
        miss_nxt = miss_inc;
      end
    end

    l_vld = s1_last_r;
    l_seg = '{mode: mode_nxt, len: hit_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NUM;
      hit_r  <= '0;
      miss_r <= '0;
    end else if (advance && s1_vld_r) begin
      mode_r <= mode_nxt;
      hit_r  <= hit_nxt;
      miss_r <= miss_nxt;
    end
  end

  // ------------------------------------------------- stage 2: segment list
  logic s2_vld_r, s2_d_vld_r, s2_l_vld_r;
  logic s2_first_r;
  seg_t s2_d_r, s2_l_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r   <= 1'b0;
      s2_d_vld_r <= 1'b0;
      s2_l_vld_r <= 1'b0;
    end else if (advance) begin
      s2_vld_r   <= s1_vld_r;
      s2_d_vld_r <= s1_vld_r && d_vld;
      s2_l_vld_r <= s1_vld_r && l_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_first_r <= s1_first_r;
      s2_d_r     <= d_seg;
      s2_l_r     <= l_seg;
    end
  end

  // ------------------------------------------------- stage 3: segment cost
  logic             s3_vld_r, s3_d_vld_r, s3_l_vld_r;
  logic             s3_first_r;
  seg_t             s3_d_r, s3_l_r;
  logic [TOT_W-1:0] s3_d_cost_r, s3_l_cost_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r   <= 1'b0;
      s3_d_vld_r <= 1'b0;
      s3_l_vld_r <= 1'b0;
    end else if (advance) begin
      s3_vld_r   <= s2_vld_r;
      s3_d_vld_r <= s2_d_vld_r;
      s3_l_vld_r <= s2_l_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_first_r  <= s2_first_r;
      s3_d_r      <= s2_d_r;
      s3_l_r      <= s2_l_r;
      s3_d_cost_r <= seg_data_bits(s2_d_r.mode, s2_d_r.len);
      s3_l_cost_r <= seg_data_bits(s2_l_r.mode, s2_l_r.len);
    end
  end

  // ----------------------------------------------- stage 3: running totals
  logic [TOT_W-1:0] tot_s_r, tot_m_r, tot_l_r;
  logic [TOT_W-1:0] t0_s, t0_m, t0_l;
  logic [TOT_W-1:0] td_s, td_m, td_l;
  logic [TOT_W-1:0] tl_s, tl_m, tl_l;
  res_t             res_d, res_l;

  always_comb begin
    // a first byte restarts the totals
    t0_s = s3_first_r ? '0 : tot_s_r;
    t0_m = s3_first_r ? '0 : tot_m_r;
    t0_l = s3_first_r ? '0 : tot_l_r;
    if (s3_d_vld_r) begin
      td_s = t0_s + s3_d_cost_r + cc_bits(s3_d_r.mode, SIZE_SMALL);
      td_m = t0_m + s3_d_cost_r + cc_bits(s3_d_r.mode, SIZE_MEDIUM);
      td_l = t0_l + s3_d_cost_r + cc_bits(s3_d_r.mode, SIZE_LARGE);
    end else begin
      td_s = t0_s;
      td_m = t0_m;
      td_l = t0_l;
    end
    tl_s = td_s + s3_l_cost_r + cc_bits(s3_l_r.mode, SIZE_SMALL);
    tl_m = td_m + s3_l_cost_r + cc_bits(s3_l_r.mode, SIZE_MEDIUM);
    tl_l = td_l + s3_l_cost_r + cc_bits(s3_l_r.mode, SIZE_LARGE);

    res_d = '{mode: s3_d_r.mode, len: s3_d_r.len, bits_small: td_s,
              bits_medium: td_m, bits_large: td_l, final_flag: 1'b0};
    res_l = '{mode: s3_l_r.mode, len: s3_l_r.len, bits_small: tl_s,
              bits_medium: tl_m, bits_large: tl_l, final_flag: 1'b1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_s_r <= '0;
      tot_m_r <= '0;
      tot_l_r <= '0;
    end else if (advance && s3_vld_r) begin
      tot_s_r <= s3_l_vld_r ? tl_s : td_s;
      tot_m_r <= s3_l_vld_r ? tl_m : td_m;
      tot_l_r <= s3_l_vld_r ? tl_l : td_l;
    end
  end

  // ------------------------------------------------------- result queue
  // Shifting queue: the head sits in entry 0, new beats land behind the tail.
  res_t              q_r   [QDEPTH];
  res_t              q_nxt [QDEPTH];
  logic              pop, push0, push1;
  res_t              p0;
  logic [QCNT_W-1:0] base;

  assign out_valid = (q_cnt_r != '0);
  assign pop       = out_valid && out_ready;

  always_comb begin
    push0 = advance && s3_vld_r && (s3_d_vld_r || s3_l_vld_r);
    push1 = advance && s3_vld_r && s3_d_vld_r && s3_l_vld_r;
    p0    = s3_d_vld_r ? res_d : res_l;
    base  = q_cnt_r - QCNT_W'(pop);

    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && i < QDEPTH - 1) begin
        q_nxt[i] = q_r[(i + 1) % QDEPTH];
      end else begin
        q_nxt[i] = q_r[i];
      end
    end
    for (int i = 0; i < QDEPTH; i++) begin
      if (push0 && QCNT_W'(i) == base) begin
        q_nxt[i] = p0;
      end
      if (push1 && QCNT_W'(i) == base + QCNT_W'(1)) begin
        q_nxt[i] = res_l;
      end
    end

    q_cnt_nxt = base + QCNT_W'(push0) + QCNT_W'(push1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign out_seg_mode    = q_r[0].mode;
  assign out_seg_len     = q_r[0].len;
  assign out_bits_small  = q_r[0].bits_small;
  assign out_bits_medium = q_r[0].bits_medium;
  assign out_bits_large  = q_r[0].bits_large;
  assign out_final_flag  = q_r[0].final_flag;

endmodule
`default_nettype wire
